/* design/stq_pkg.sv */
// Shared types and constants for the sorted timer task queue.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_W          = 8;
    localparam int DELAY_W         = 16;
    localparam int ACTION_W        = 2;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd2;

    typedef struct packed {
        logic               used;
        logic [TASK_W-1:0]  task_id;
        logic [DELAY_W-1:0] delay;
    } slot_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [TASK_W-1:0]  task_id;
        logic [DELAY_W-1:0] delay;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* design/stq_cell.sv */
// One queue slot: holds a task and its delay, shifts to and from its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module stq_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stq_pkg::cell_cmd_t cmd,
    input  wire stq_pkg::slot_t    left_slot,
    input  wire logic              left_le,
    input  wire stq_pkg::slot_t    right_slot,
    input  wire logic              hit_in,
    output stq_pkg::slot_t         slot,
    output logic                   le,
    output logic                   hit,
    output logic                   hit_out
);

    stq_pkg::slot_t slot_reg;
    stq_pkg::slot_t slot_next;

    assign slot    = slot_reg;
    assign hit     = slot_reg.used && (slot_reg.task_id == cmd.task_id);
    assign hit_out = hit_in || hit;
    assign le      = slot_reg.used && (slot_reg.delay <= cmd.delay);

    always_comb
    begin
        slot_next = slot_reg;
        unique case (cmd.op)
            stq_pkg::CELL_HOLD:
            begin
                slot_next = slot_reg;
            end
            stq_pkg::CELL_REMOVE:
            begin
                if (hit_out)
                begin
                    slot_next = right_slot;
                end
            end
            stq_pkg::CELL_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        slot_next.used    = 1'b1;
                        slot_next.task_id = cmd.task_id;
                        slot_next.delay   = cmd.delay;
                    end
                    else
                    begin
                        slot_next = left_slot;
                    end
                end
            end
            stq_pkg::CELL_POP:
            begin
                slot_next.used    = right_slot.used;
                slot_next.task_id = right_slot.task_id;
                slot_next.delay   = (right_slot.delay > cmd.delay) ?
                                    (right_slot.delay - cmd.delay) : '0;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

/* design/sorted_timer_task_queue_core.sv */
// Top level of the sorted timer task queue: control sequencer and row of slot cells.
`timescale 1ns / 1ps
`default_nettype none

// Timer queue of task ids kept in delay order in a row of QUEUE_DEPTH slot cells,
// head in cell 0. Each request carries one action (add, tick, dispatch) and gives
// exactly one response. An add runs through search and removal of a queued id in
// one pass over the row, then a sorted insert pass, then head reload with the
// response. A dispatch makes one shift pass with delay rebase, then a head reload;
// a tick or an unused action goes straight to the response step. One request is in
// flight at a time; the next is accepted once the response is registered. A response
// still waiting in the output register holds the request in its last step.
module sorted_timer_task_queue_core #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // action[1:0], task_id[9:2], delay[25:10], zero[31:26]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // dispatched[0], dispatched_task[8:1],
                                        // add_dropped[9], ready_res[10], queue_count[15:11]
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = stq_pkg::TASK_W;
    localparam int DW    = stq_pkg::DELAY_W;
    localparam int OCW   = stq_pkg::COUNT_OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_INS,
        ST_DISP,
        ST_FIN
    } state_t;

    state_t                         state_reg,  state_next;
    logic [stq_pkg::ACTION_W-1:0]   act_reg,    act_next;
    logic [TW-1:0]                  id_reg,     id_next;
    logic [DW-1:0]                  dly_reg,    dly_next;
    logic [DW-1:0]                  nd_reg,     nd_next;
    logic                           found_reg,  found_next;
    logic                           drop_reg,   drop_next;
    logic                           pop_reg,    pop_next;
    logic [TW-1:0]                  pid_reg,    pid_next;
    logic [CNT_W-1:0]               count_reg,  count_next;
    logic [DW-1:0]                  head_reg,   head_next;
    logic [DW-1:0]                  base_reg,   base_next;
    logic                           ready_reg,  ready_next;
    logic                           ovalid_reg, ovalid_next;
    logic [15:0]                    odata_reg,  odata_next;

    stq_pkg::cell_cmd_t             cmd;
    stq_pkg::slot_t                 slots    [QUEUE_DEPTH];
    logic                           les      [QUEUE_DEPTH];
    logic                           hits     [QUEUE_DEPTH];
    logic                           hit_outs [QUEUE_DEPTH];

    logic                           any_hit;
    logic [DW-1:0]                  found_dly;
    logic [DW:0]                    sum;
    logic [DW-1:0]                  hr_dec;
    logic [CNT_W+OCW-1:0]           cnt_ext;
    logic [TW-1:0]                  in_id;
    logic [DW-1:0]                  in_dly;
    logic [stq_pkg::ACTION_W-1:0]   in_act;

    localparam stq_pkg::slot_t EMPTY_SLOT = '0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            stq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_slot  ((g == 0) ? EMPTY_SLOT : slots[(g == 0) ? 0 : g - 1]),
                .left_le    ((g == 0) ? 1'b1 : les[(g == 0) ? 0 : g - 1]),
                .right_slot ((g == QUEUE_DEPTH - 1) ? EMPTY_SLOT :
                             slots[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .hit_in     ((g == 0) ? 1'b0 : hit_outs[(g == 0) ? 0 : g - 1]),
                .slot       (slots[g]),
                .le         (les[g]),
                .hit        (hits[g]),
                .hit_out    (hit_outs[g])
            );
        end
    endgenerate

    always_comb
    begin
        found_dly = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (hits[i])
            begin
                found_dly = found_dly | slots[i].delay;
            end
        end
    end

    assign any_hit  = hit_outs[QUEUE_DEPTH-1];
    assign sum      = {1'b0, found_dly} + {1'b0, dly_reg};
    assign hr_dec   = (!ready_reg && head_reg != '0) ? head_reg - 1'b1 : head_reg;
    assign cnt_ext  = {{OCW{1'b0}}, count_reg};
    assign in_act   = s_tdata[1:0];
    assign in_id    = s_tdata[9:2];
    assign in_dly   = (s_tdata[25:10] == '0) ? DW'(1) : s_tdata[25:10];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        dly_next    = dly_reg;
        nd_next     = nd_reg;
        found_next  = found_reg;
        drop_next   = drop_reg;
        pop_next    = pop_reg;
        pid_next    = pid_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        base_next   = base_reg;
        ready_next  = ready_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        cmd.op      = stq_pkg::CELL_HOLD;
        cmd.task_id = id_reg;
        cmd.delay   = nd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = in_act;
                    id_next    = in_id;
                    dly_next   = in_dly;
                    found_next = 1'b0;
                    drop_next  = 1'b0;
                    pop_next   = 1'b0;
                    pid_next   = '0;
                    case (in_act)
                        stq_pkg::ACT_ADD:      state_next = ST_SRCH;
                        stq_pkg::ACT_DISPATCH: state_next = ST_DISP;
                        default:               state_next = ST_FIN;
                    endcase
                end
            end
            ST_SRCH:
            begin
                // find the id and close its gap in the same pass
                cmd.op     = stq_pkg::CELL_REMOVE;
                found_next = any_hit;
                nd_next    = !any_hit ? dly_reg : (sum[DW] ? '1 : sum[DW-1:0]);
                drop_next  = !any_hit && (count_reg == CNT_W'(QUEUE_DEPTH));
                state_next = ST_INS;
            end
            ST_INS:
            begin
                if (!drop_reg)
                begin
                    cmd.op = stq_pkg::CELL_INSERT;
                    if (!found_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = ST_FIN;
            end
            ST_DISP:
            begin
                if (ready_reg && count_reg != '0)
                begin
                    cmd.op     = stq_pkg::CELL_POP;
                    cmd.delay  = base_reg;
                    pop_next   = 1'b1;
                    pid_next   = slots[0].task_id;
                    count_next = count_reg - 1'b1;
                    ready_next = 1'b0;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    case (act_reg)
                        stq_pkg::ACT_ADD:
                        begin
                            if (!drop_reg && slots[0].used && slots[0].task_id == id_reg)
                            begin
                                head_next = slots[0].delay;
                                base_next = slots[0].delay;
                            end
                        end
                        stq_pkg::ACT_TICK:
                        begin
                            head_next = hr_dec;
                            if (hr_dec == '0)
                            begin
                                ready_next = 1'b1;
                            end
                        end
                        stq_pkg::ACT_DISPATCH:
                        begin
                            if (pop_reg && count_reg != '0)
                            begin
                                head_next = slots[0].delay;
                                base_next = slots[0].delay;
                            end
                        end
                        default:
                        begin
                            head_next = head_reg;
                        end
                    endcase
                    ovalid_next = 1'b1;
                    odata_next  = {cnt_ext[OCW-1:0], ready_next, drop_reg,
                                   (pop_reg ? pid_reg : {TW{1'b0}}), pop_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            act_reg    <= '0;
            id_reg     <= '0;
            dly_reg    <= '0;
            nd_reg     <= '0;
            found_reg  <= 1'b0;
            drop_reg   <= 1'b0;
            pop_reg    <= 1'b0;
            pid_reg    <= '0;
            count_reg  <= '0;
            head_reg   <= '0;
            base_reg   <= '0;
            ready_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            id_reg     <= id_next;
            dly_reg    <= dly_next;
            nd_reg     <= nd_next;
            found_reg  <= found_next;
            drop_reg   <= drop_next;
            pop_reg    <= pop_next;
            pid_reg    <= pid_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            base_reg   <= base_next;
            ready_reg  <= ready_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
        end
    end

endmodule

`default_nettype wire
